### rtl/core/lookahead_heading_error_unit_macros.svh
// Assertion macros for the lookahead heading error unit.
// LHE_ASSERT_NOW checks a consequence in the same cycle as its antecedent,
// LHE_ASSERT_NEXT checks it in the cycle after.
`ifndef LOOKAHEAD_HEADING_ERROR_UNIT_MACROS_SVH
`define LOOKAHEAD_HEADING_ERROR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LHE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lhe assertion failed");
`define LHE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lhe assertion failed");
`else
`define LHE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LHE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/lhe_pkg.sv
package lhe_pkg;

  // Radius register.
  localparam int RADIUS_W = 16;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd300;

  // CORDIC datapath. Angles are unsigned fractions of a full turn.
  localparam int TURN_W        = 32;
  localparam int NORM_BIT      = 40;
  localparam int MAG_W         = NORM_BIT + 1;
  localparam int CORDIC_W      = 44;
  localparam int COARSE_SHIFT  = 8;
  localparam int ATAN_DEPTH    = 24;
  localparam int ATAN_IDX_W    = 5;
  localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;

  // Depth of the queue between the selection front and the CORDIC back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SQUARE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_NORM,
    B_ITER,
    B_FINISH
  } back_state_t;

  // atan(2^-i) in units of 2^-32 of a full turn.
  function automatic logic [TURN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [TURN_W-1:0] val;
    unique case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10679838;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

### rtl/core/lhe_in_if.sv
interface lhe_in_if #(
  parameter int POSITION_BITS = 24,
  parameter int ANGLE_BITS    = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] point_x;
  logic signed [POSITION_BITS-1:0] point_y;
  logic signed [POSITION_BITS-1:0] robot_x;
  logic signed [POSITION_BITS-1:0] robot_y;
  logic signed [ANGLE_BITS-1:0]    bot_heading;
  logic                            last_point;

  modport source (
    output valid, point_x, point_y, robot_x, robot_y, bot_heading, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, robot_x, robot_y, bot_heading, last_point,
    output ready
  );
endinterface

### rtl/core/lhe_out_if.sv
interface lhe_out_if #(
  parameter int ANGLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [ANGLE_BITS:0]  steer_angle;
  logic                        far_point_found;

  modport source (
    output valid, steer_angle, far_point_found,
    input  ready
  );
  modport sink (
    input  valid, steer_angle, far_point_found,
    output ready
  );
endinterface

### rtl/core/lhe_front.sv
module lhe_front
  import lhe_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int ANGLE_BITS    = 16,
  parameter int ENTRY_W       = 1 + ANGLE_BITS + 2 * (POSITION_BITS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  lhe_in_if.sink              in_ch,
  input  logic [RADIUS_W-1:0] radius,
  input  logic                q_full,
  output logic                q_push,
  output logic [ENTRY_W-1:0]  q_data
);

  localparam int DW = POSITION_BITS + 1;

  front_state_t state_r, state_nxt;

  logic signed [DW-1:0]         dx_r, dy_r;
  logic signed [ANGLE_BITS-1:0] yaw_r;
  logic                         last_r;
  logic                         over_r;
  logic [2*RADIUS_W-1:0]        sqx_r, sqy_r;
  logic [2*RADIUS_W-1:0]        rsq_r;

  logic                         found_r, found_nxt;
  logic signed [DW-1:0]         held_dx_r, held_dx_nxt;
  logic signed [DW-1:0]         held_dy_r, held_dy_nxt;

  logic                         load;
  logic signed [DW-1:0]         negx, negy;
  logic [POSITION_BITS-1:0]     ax, ay;
  logic [2*RADIUS_W:0]          sq_sum;
  logic                         beyond;
  logic                         sel_found;
  logic signed [DW-1:0]         sel_dx, sel_dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      found_r   <= 1'b0;
      held_dx_r <= '0;
      held_dy_r <= '0;
    end else begin
      state_r   <= state_nxt;
      found_r   <= found_nxt;
      held_dx_r <= held_dx_nxt;
      held_dy_r <= held_dy_nxt;
    end
  end

  // Squared radius is a registered copy of the radius register squared.
  always_ff @(posedge clk) begin
    rsq_r <= radius * radius;
    if (load) begin
      dx_r   <= {in_ch.point_x[POSITION_BITS-1], in_ch.point_x}
              - {in_ch.robot_x[POSITION_BITS-1], in_ch.robot_x};
      dy_r   <= {in_ch.point_y[POSITION_BITS-1], in_ch.point_y}
              - {in_ch.robot_y[POSITION_BITS-1], in_ch.robot_y};
      yaw_r  <= in_ch.bot_heading;
      last_r <= in_ch.last_point;
    end
    if (state_r == F_SQUARE) begin
      over_r <= (ax > POSITION_BITS'(radius)) || (ay > POSITION_BITS'(radius));
      // Exact only when both magnitudes fit the radius; otherwise over_r wins.
      sqx_r  <= ax[RADIUS_W-1:0] * ax[RADIUS_W-1:0];
      sqy_r  <= ay[RADIUS_W-1:0] * ay[RADIUS_W-1:0];
    end
  end

  always_comb begin
    negx = -dx_r;
    negy = -dy_r;
    ax   = dx_r[DW-1] ? negx[POSITION_BITS-1:0] : dx_r[POSITION_BITS-1:0];
    ay   = dy_r[DW-1] ? negy[POSITION_BITS-1:0] : dy_r[POSITION_BITS-1:0];

    sq_sum    = {1'b0, sqx_r} + {1'b0, sqy_r};
    beyond    = over_r || (sq_sum > {1'b0, rsq_r});
    sel_found = found_r | beyond;
    sel_dx    = found_r ? held_dx_r : dx_r;
    sel_dy    = found_r ? held_dy_r : dy_r;
    q_data    = {sel_found, yaw_r, sel_dy, sel_dx};
  end

  always_comb begin
    state_nxt   = state_r;
    found_nxt   = found_r;
    held_dx_nxt = held_dx_r;
    held_dy_nxt = held_dy_r;
    load        = 1'b0;
    q_push      = 1'b0;
    in_ch.ready = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          load      = 1'b1;
          state_nxt = F_SQUARE;
        end
      end
      F_SQUARE: begin
        state_nxt = F_UPDATE;
      end
      F_UPDATE: begin
        if (!last_r) begin
          found_nxt   = sel_found;
          held_dx_nxt = sel_dx;
          held_dy_nxt = sel_dy;
          state_nxt   = F_IDLE;
        end else if (!q_full) begin
          // Path ends: hand the chosen offset to the back and start afresh.
          q_push      = 1'b1;
          found_nxt   = 1'b0;
          held_dx_nxt = '0;
          held_dy_nxt = '0;
          state_nxt   = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

endmodule

### rtl/core/lhe_queue.sv
module lhe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == CNT_W'(DEPTH));
    empty      = (count_r == '0);
    rd_data    = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/core/lhe_cordic.sv
module lhe_cordic
  import lhe_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STEPS  = 16,
  parameter int ENTRY_W       = 1 + ANGLE_BITS + 2 * (POSITION_BITS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               q_pop,
  lhe_out_if.source          out_ch
);

  localparam int DW = POSITION_BITS + 1;

  back_state_t state_r, state_nxt;

  logic [MAG_W-1:0]             mx_r, my_r;
  logic signed [CORDIC_W-1:0]   x_r, y_r;
  logic [TURN_W-1:0]            z_r;
  logic [ATAN_IDX_W-1:0]        cnt_r;
  logic                         xneg_r, yflip_r, found_r;
  logic signed [ANGLE_BITS-1:0] yaw_r;

  logic                         out_valid_r;
  logic signed [ANGLE_BITS:0]   out_yaw_r;
  logic                         out_found_r;

  logic signed [DW-1:0]         e_dx, e_dy, e_negx, e_negy;
  logic signed [ANGLE_BITS-1:0] e_yaw;
  logic                         e_found;
  logic [POSITION_BITS-1:0]     e_ax, e_ay;
  logic [MAG_W-1:0]             mag_or;
  logic [CORDIC_W-1:0]          mx_ext, my_ext;
  logic signed [CORDIC_W-1:0]   xs, ys;
  logic [TURN_W-1:0]            z_round;
  logic [ANGLE_BITS-1:0]        ang, diff;
  logic signed [ANGLE_BITS:0]   err_ext, tyaw;
  logic                         out_load;

  always_comb begin
    {e_found, e_yaw, e_dy, e_dx} = q_data;
    e_negx  = -e_dx;
    e_negy  = -e_dy;
    e_ax    = e_dx[DW-1] ? e_negx[POSITION_BITS-1:0] : e_dx[POSITION_BITS-1:0];
    e_ay    = e_dy[DW-1] ? e_negy[POSITION_BITS-1:0] : e_dy[POSITION_BITS-1:0];

    mag_or  = mx_r | my_r;
    mx_ext  = CORDIC_W'(mx_r);
    my_ext  = CORDIC_W'(my_r);
    xs      = x_r >>> cnt_r;
    ys      = y_r >>> cnt_r;

    z_round = z_r + (TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS));
    ang     = z_round[TURN_W-1 -: ANGLE_BITS];
    diff    = ang - yaw_r;
    err_ext = {diff[ANGLE_BITS-1], diff};
    tyaw    = -err_ext;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = ((e_dx == '0) && (e_dy == '0)) ? B_FINISH : B_NORM;
        end
      end
      B_NORM: begin
        if (mag_or[NORM_BIT]) begin
          state_nxt = B_ITER;
        end
      end
      B_ITER: begin
        if (cnt_r == ATAN_IDX_W'(CORDIC_STEPS - 1)) begin
          state_nxt = B_FINISH;
        end
      end
      B_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        mx_r    <= MAG_W'(e_ax);
        my_r    <= MAG_W'(e_ay);
        xneg_r  <= e_dx[DW-1];
        yflip_r <= e_dx[DW-1] ^ e_dy[DW-1];
        yaw_r   <= e_yaw;
        found_r <= e_found;
        z_r     <= '0;
      end
      B_NORM: begin
        if (mag_or[NORM_BIT]) begin
          // Left half-plane is folded over by adding half a turn.
          x_r   <= mx_ext;
          y_r   <= yflip_r ? -my_ext : my_ext;
          z_r   <= xneg_r ? HALF_TURN : '0;
          cnt_r <= '0;
        end else if (mag_or[NORM_BIT -: COARSE_SHIFT] == '0) begin
          mx_r <= mx_r << COARSE_SHIFT;
          my_r <= my_r << COARSE_SHIFT;
        end else begin
          mx_r <= mx_r << 1;
          my_r <= my_r << 1;
        end
      end
      B_ITER: begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + atan_turn(cnt_r);
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - atan_turn(cnt_r);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_yaw_r   <= tyaw;
      out_found_r <= found_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.steer_angle     = out_yaw_r;
  assign out_ch.far_point_found = out_found_r;

endmodule

### rtl/core/lookahead_heading_error_unit.sv
// Channel    Dir  Payload                                                   Beat when
// in_ch      in   point_x/y, robot_x/y, bot_heading, last_point             valid & ready
// out_ch     out  steer_angle, far_point_found                              valid & ready
// cfg_wr_*   in   reach_radius (16 bit)                                     cfg_wr_en high
//
// Every input beat occupies the selection front through offset, squares and update.
// A last-point beat also takes the CORDIC back through pop, normalize, CORDIC_STEPS
// iterations and finish, or pop and finish alone for a zero offset; the back takes no
// new entry until it has finished the last one.
// The 2-entry queue lets the front keep taking points while the back works.
// rst_n is synchronous and active low; the radius resets to 300 mm, path state to zero.
// A stalled out_ch holds its result; the back then waits, and the front stalls once
// the queue is full and a path's last point has to be handed on.
`include "lookahead_heading_error_unit_macros.svh"
module lookahead_heading_error_unit
  import lhe_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  lhe_in_if.sink              in_ch,
  lhe_out_if.source           out_ch,
  input  logic                cfg_wr_en,
  input  logic [RADIUS_W-1:0] cfg_wr_data
);

  // One queue entry carries the chosen offset, the yaw of the last point
  // and whether a far point was found.
  localparam int ENTRY_W = 1 + ANGLE_BITS + 2 * (POSITION_BITS + 1);

  logic [RADIUS_W-1:0] radius_r;
  logic                q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0]  q_wr_data, q_rd_data;

  // The radius register is to be written only while the unit is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // Front: forms each offset, runs the squared-distance test and holds the
  // first offset beyond the radius (or the latest one) until the path ends.
  lhe_front #(
    .POSITION_BITS (POSITION_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .ENTRY_W       (ENTRY_W)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .radius (radius_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  lhe_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: normalizes the offset, runs the vectoring CORDIC, subtracts the
  // yaw, wraps, negates and holds the result in the output register.
  lhe_cordic #(
    .POSITION_BITS (POSITION_BITS),
    .ANGLE_BITS    (ANGLE_BITS),
    .CORDIC_STEPS  (CORDIC_STEPS),
    .ENTRY_W       (ENTRY_W)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // The front never writes a full queue, and the back never reads an empty one.
  `LHE_ASSERT_NOW(a_queue_no_overflow, clk, rst_n, q_push, !q_full)
  `LHE_ASSERT_NOW(a_queue_no_underflow, clk, rst_n, q_pop, !q_empty)
  // Once an entry is taken the back is busy, so it cannot take another next cycle.
  `LHE_ASSERT_NEXT(a_back_one_at_a_time, clk, rst_n, q_pop, !q_pop)

endmodule

### dv/lhe_tb_pkg.sv
`timescale 1ns / 1ps

package lhe_tb_pkg;
  import lhe_pkg::*;

  localparam int POS_W        = 24;
  localparam int ANG_W        = 16;
  localparam int CORDIC_ITERS = 16;

  // atan(2^-i) in units of 2^-32 of a full turn.
  localparam logic [TURN_W-1:0] ATAN_STEP [ATAN_DEPTH] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct {
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic signed [POS_W-1:0] robot_x;
    logic signed [POS_W-1:0] robot_y;
    logic signed [ANG_W-1:0] bot_heading;
    logic                    last_point;
  } path_beat_t;

  typedef struct {
    logic signed [ANG_W:0] steer_angle;
    logic                  far_point_found;
  } steer_result_t;

  // Bearing of (dx, dy) as an unsigned fraction of a full turn.
  function automatic logic [TURN_W-1:0] bearing_turns(longint dy, longint dx);
    longint unsigned mx;
    longint unsigned my;
    longint unsigned mm;
    longint          x;
    longint          y;
    longint          xs;
    longint          ys;
    logic [TURN_W-1:0] z;
    int              sh;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    if (mx == 0 && my == 0) return '0;
    mm = (mx > my) ? mx : my;
    sh = 0;
    while ((mm << sh) < (64'd1 << NORM_BIT)) sh++;
    x = longint'(mx << sh);
    y = longint'(my << sh);
    if (dx < 0) x = -x;
    if (dy < 0) y = -y;
    z = '0;
    // Fold the left half plane onto the right one.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_ITERS && i < ATAN_DEPTH; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  class heading_scoreboard;
    logic [RADIUS_W-1:0] reach_mm;
    bit                  far_held;
    longint              held_dx;
    longint              held_dy;
    steer_result_t       pending_yaws[$];
    int                  mismatches;

    function new();
      reach_mm   = RADIUS_RESET;
      far_held   = 1'b0;
      held_dx    = 0;
      held_dy    = 0;
      mismatches = 0;
    endfunction

    function void set_radius(logic [RADIUS_W-1:0] r);
      reach_mm = r;
    endfunction

    function int pending_count();
      return pending_yaws.size();
    endfunction

    function int failures();
      return mismatches;
    endfunction

    // Track the held offset; a marked last point closes the path.
    function void note_point(path_beat_t b);
      longint            dx;
      longint            dy;
      longint unsigned   ax;
      longint unsigned   ay;
      longint unsigned   r;
      logic [TURN_W:0]   rounded;
      logic [ANG_W-1:0]  ang;
      logic [ANG_W-1:0]  diff;
      steer_result_t     res;
      dx = longint'(b.point_x) - longint'(b.robot_x);
      dy = longint'(b.point_y) - longint'(b.robot_y);
      r  = reach_mm;
      if (!far_held) begin
        held_dx = dx;
        held_dy = dy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > r || ay > r || ax * ax + ay * ay > r * r) far_held = 1'b1;
      end
      if (!b.last_point) return;
      rounded = {1'b0, bearing_turns(held_dy, held_dx)} + (33'd1 << (TURN_W - ANG_W - 1));
      ang  = rounded[TURN_W-1:TURN_W-ANG_W];
      diff = ang - b.bot_heading;
      res.steer_angle     = -{diff[ANG_W-1], diff};
      res.far_point_found = far_held;
      pending_yaws.push_back(res);
      far_held = 1'b0;
      held_dx  = 0;
      held_dy  = 0;
    endfunction

    function void check_result(logic signed [ANG_W:0] yaw, logic far);
      steer_result_t want;
      if (pending_yaws.size() == 0) begin
        if (mismatches < 10)
          $display("ERROR: unexpected result steer_angle=%0d far=%0b", yaw, far);
        mismatches++;
        return;
      end
      want = pending_yaws.pop_front();
      if (yaw !== want.steer_angle || far !== want.far_point_found) begin
        if (mismatches < 10)
          $display("ERROR: steer_angle exp %0d got %0d, far_point_found exp %0b got %0b",
                   want.steer_angle, yaw, want.far_point_found, far);
        mismatches++;
      end
    endfunction

    function void close_out();
      if (pending_yaws.size() != 0) begin
        $display("ERROR: %0d results never arrived", pending_yaws.size());
        mismatches += pending_yaws.size();
      end
    endfunction
  endclass

endpackage

### dv/lookahead_heading_error_unit_tb.sv
`timescale 1ns / 1ps

module lookahead_heading_error_unit_tb;
  import lhe_pkg::*;
  import lhe_tb_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_TICKS = 60;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [RADIUS_W-1:0] cfg_wr_data;

  lhe_in_if #(.POSITION_BITS(POS_W), .ANGLE_BITS(ANG_W)) in_ch ();
  lhe_out_if #(.ANGLE_BITS(ANG_W)) out_ch ();

  lookahead_heading_error_unit #(
    .POSITION_BITS(POS_W),
    .ANGLE_BITS   (ANG_W),
    .CORDIC_STEPS (CORDIC_ITERS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  heading_scoreboard sb = new();

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // A request for one long receiver hold-off, served by the ready process.
  bit hold_request   = 1'b0;
  int hold_left      = 0;
  int reach_now      = RADIUS_RESET;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The run is bounded in time no matter how the block behaves.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver side. Ready is redrawn every cycle from the current stall rate,
  // except during a long hold-off, which lets the internal queue fill up so
  // that the input side has to stall as well.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every accepted result beat goes straight to the scoreboard. Values are
  // sampled at the edge, before any nonblocking update of that edge lands.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.steer_angle, out_ch.far_point_found);
  end

  // Offer one path point and hold it until the block takes it. Idle cycles
  // are drawn before the beat according to the sender idle rate. Valid stays
  // high from one beat to the next when no idle cycle is drawn.
  task automatic offer_point(input longint px, input longint py, input longint rx,
                             input longint ry, input int yaw, input bit last);
    path_beat_t b;
    b.point_x     = px[POS_W-1:0];
    b.point_y     = py[POS_W-1:0];
    b.robot_x     = rx[POS_W-1:0];
    b.robot_y     = ry[POS_W-1:0];
    b.bot_heading = yaw[ANG_W-1:0];
    b.last_point  = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.point_x     <= b.point_x;
    in_ch.point_y     <= b.point_y;
    in_ch.robot_x     <= b.robot_x;
    in_ch.robot_y     <= b.robot_y;
    in_ch.bot_heading <= b.bot_heading;
    in_ch.last_point  <= b.last_point;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_point(b);
  endtask

  // Stop offering, wait until every predicted result has come back, then
  // give the block time to finish any unmarked point still in its front end.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_radius(input int r);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r[RADIUS_W-1:0];
    @(posedge clk);
    sb.set_radius(r[RADIUS_W-1:0]);
    reach_now = r;
    cfg_wr_en <= 1'b0;
  endtask

  // Random paths of one to max_len points. Most offsets sit inside, on or
  // just past the radius so that the selection is exercised at its edge;
  // others span the whole position range.
  task automatic send_random_paths(input int n_items, input int max_len);
    int     sent;
    int     len;
    int     roll;
    int     k_bits;
    longint r;
    longint rx;
    longint ry;
    longint ox;
    longint oy;
    longint swap;
    longint px;
    longint py;
    sent = 0;
    r    = reach_now;
    while (sent < n_items) begin
      len = $urandom_range(max_len, 1);
      if ($urandom_range(3) == 0) begin
        rx = $urandom;
        ry = $urandom;
      end else begin
        rx = longint'($urandom_range(200000)) - 100000;
        ry = longint'($urandom_range(200000)) - 100000;
      end
      for (int k = 0; k < len; k++) begin
        // The robot may move between points of one path.
        if ($urandom_range(4) == 0) begin
          rx = rx + longint'($urandom_range(64)) - 32;
          ry = ry + longint'($urandom_range(64)) - 32;
        end
        roll = $urandom_range(99);
        ox = 0;
        oy = 0;
        if (roll < 5) begin
          ox = 0;
        end else if (roll < 35) begin
          ox = longint'($urandom_range(r)) - r / 2;
          oy = longint'($urandom_range(r)) - r / 2;
        end else if (roll < 60) begin
          // Near the circle: one unit either side of the exact boundary.
          ox = longint'($urandom_range(2 * r)) - r;
          oy = longint'($floor($sqrt(real'(r * r - ox * ox))));
          oy = oy + longint'($urandom_range(2)) - 1;
          if ($urandom_range(1)) oy = -oy;
          if ($urandom_range(1)) begin
            swap = ox;
            ox   = oy;
            oy   = swap;
          end
        end else if (roll < 88) begin
          k_bits = $urandom_range(POS_W, 1);
          ox = longint'($urandom_range((1 << k_bits) - 1)) - (longint'(1) << (k_bits - 1));
          oy = longint'($urandom_range((1 << k_bits) - 1)) - (longint'(1) << (k_bits - 1));
        end
        if (roll >= 88) begin
          px = $urandom;
          py = $urandom;
        end else begin
          px = rx + ox;
          py = ry + oy;
        end
        offer_point(px, py, rx, ry, $urandom, k == len - 1);
      end
      sent += len;
    end
  endtask

  // One phase: drain, set the radius, set the idling rates, send paths.
  task automatic run_phase(input int r, input int s_pct, input int r_pct,
                           input int n_items, input bit squeeze);
    wait_drain();
    write_radius(r);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    if (squeeze) begin
      // Single-point paths, each one a result, while the receiver holds off.
      hold_request = 1'b1;
      send_random_paths(n_items, 1);
    end else begin
      send_random_paths(n_items, 6);
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.point_x     <= '0;
    in_ch.point_y     <= '0;
    in_ch.robot_x     <= '0;
    in_ch.robot_y     <= '0;
    in_ch.bot_heading <= '0;
    in_ch.last_point  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats at the reset radius of 300 mm, no idling.
    // A zero offset has heading 0, so the result is just the yaw.
    offer_point(0, 0, 0, 0, 1234, 1'b1);
    // An offset on the negative x axis points at pi, which wraps to -pi and is negated to +pi.
    offer_point(-1000, 0, 0, 0, 0, 1'b1);
    // Yaw at both ends of its range.
    offer_point(5000, 0, 0, 0, -32768, 1'b1);
    offer_point(0, 5000, 0, 0, 32767, 1'b1);
    // The second point is the first beyond the radius; the third is ignored.
    offer_point(100, 100, 0, 0, 7, 1'b0);
    offer_point(400, 0, 0, 0, 99, 1'b0);
    offer_point(0, -5000, 0, 0, -4000, 1'b1);
    // No point beyond the radius: the last point's offset is used.
    offer_point(10, 10, 0, 0, 0, 1'b0);
    offer_point(-20, 5, 0, 0, 0, 1'b0);
    offer_point(299, 0, 0, 0, 100, 1'b1);
    // Exactly on the circle is not beyond it; one more millimetre is.
    offer_point(300, 0, 0, 0, 0, 1'b1);
    offer_point(301, 0, 0, 0, 0, 1'b1);
    offer_point(180, 240, 0, 0, 0, 1'b1);
    offer_point(180, 241, 0, 0, 0, 1'b1);
    // Largest offsets the position fields allow, in both directions.
    offer_point(8388607, -8388608, -8388608, 8388607, 16384, 1'b1);
    offer_point(-8388608, 8388607, 8388607, -8388608, -16384, 1'b1);
    // Each point is measured from the pose that comes with it.
    offer_point(1000, 1000, 900, 900, 500, 1'b0);
    offer_point(1000, 1000, 0, 0, -500, 1'b1);
    // Tiny offsets just off the origin.
    offer_point(-1, 0, 0, 0, 0, 1'b1);
    offer_point(0, -1, 0, 0, 0, 1'b1);

    // Random phases across radius settings, extremes included, and idling.
    run_phase(0, 0, 0, 100, 1'b0);
    run_phase(65535, 80, 0, 100, 1'b0);
    run_phase(1000, 0, 80, 100, 1'b0);
    run_phase($urandom_range(65535), 25, 25, 110, 1'b0);
    run_phase(300, 0, 0, 80, 1'b1);
    run_phase(1, 0, 0, 100, 1'b0);
    run_phase($urandom_range(65535), 25, 25, 120, 1'b0);
    run_phase($urandom_range(65535), 0, 80, 100, 1'b0);

    wait_drain();
    sb.close_out();
    if (sb.failures() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
